// ----- hdl/ansi_text_terminal_engine_top_macros.svh -----
// Assertion macros shared by the terminal engine checker.
// Needs clk and rst_n visible at the point of use.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_TOP_MACROS_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_TOP_MACROS_SVH

// next-cycle implication, off while in reset
`define ATTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, off while in reset
`define ATTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define ATTE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/atte_pkg.sv -----
// Shared types, sizes and byte codes for the ANSI text terminal engine.
// No dependencies.
package atte_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_PARAMS = 8;

  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int COLI_W = $clog2(MAX_COLS);
  localparam int ROWI_W = $clog2(MAX_ROWS);
  localparam int ROW_W  = ROWI_W + 1;
  localparam int PIDX_W = $clog2(MAX_PARAMS);
  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);
  localparam int ADDR_W = ROWI_W + COLI_W;

  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int LIN_W       = 14;
  localparam int RROW_W      = 6;
  localparam int RCOL_W      = 7;
  localparam int OROW_W      = 6;
  localparam int PARAM_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int CROWS_W     = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  localparam logic [COL_W-1:0]   COLUMNS_RST = 8'd80;
  localparam logic [CROWS_W-1:0] ROWS_RST    = 7'd25;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR    = 8'h20;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h0F;
  localparam logic [COLOR_W-1:0] BRIGHT_FG     = 8'h08;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_PRIV  = 8'h3F;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] FIN_CUU    = 8'h41;
  localparam logic [7:0] FIN_CUD    = 8'h42;
  localparam logic [7:0] FIN_CUF    = 8'h43;
  localparam logic [7:0] FIN_CUB    = 8'h44;
  localparam logic [7:0] FIN_CUP    = 8'h48;
  localparam logic [7:0] FIN_HVP    = 8'h66;
  localparam logic [7:0] FIN_ED     = 8'h4A;
  localparam logic [7:0] FIN_EL     = 8'h4B;
  localparam logic [7:0] FIN_SGR    = 8'h6D;

  localparam logic [2:0] SGR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI} parse_mode_t;

  typedef enum logic [1:0] {ACT_DONE, ACT_PLAIN, ACT_FILL, ACT_SGR} act_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_FILL, ST_SGR, ST_CHECK,
    ST_COPY_RD, ST_COPY_WR, ST_SFILL, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
    logic fill_step;
    logic sgr_step;
    logic scroll_start;
    logic copy_rd;
    logic copy_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    act_t act;
    logic fill_last;
    logic sgr_last;
    logic need_scroll;
    logic copy_none;
    logic copy_last;
  } sts_t;

endpackage

// ----- hdl/atte_ctrl.sv -----
// Sequencer for the terminal engine: item handshake, command issue, result slot.
// Depends on atte_pkg.
module atte_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  atte_pkg::sts_t  sts,
  output atte_pkg::cmd_t  cmd
);

  atte_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atte_pkg::ST_CLEAR:   if (sts.fill_last) state_nxt = atte_pkg::ST_IDLE;
      atte_pkg::ST_IDLE:    if (in_valid) state_nxt = atte_pkg::ST_EXEC;
      atte_pkg::ST_EXEC: begin
        if (sts.kind) begin
          state_nxt = atte_pkg::ST_OUT;
        end else begin
          unique case (sts.act)
            atte_pkg::ACT_DONE:  state_nxt = atte_pkg::ST_OUT;
            atte_pkg::ACT_PLAIN: state_nxt = atte_pkg::ST_CHECK;
            atte_pkg::ACT_FILL:  state_nxt = atte_pkg::ST_FILL;
            atte_pkg::ACT_SGR:   state_nxt = atte_pkg::ST_SGR;
            default:             state_nxt = atte_pkg::ST_OUT;
          endcase
        end
      end
      atte_pkg::ST_FILL:    if (sts.fill_last) state_nxt = atte_pkg::ST_CHECK;
      atte_pkg::ST_SGR:     if (sts.sgr_last) state_nxt = atte_pkg::ST_CHECK;
      atte_pkg::ST_CHECK: begin
        if (!sts.need_scroll) state_nxt = atte_pkg::ST_OUT;
        else if (sts.copy_none) state_nxt = atte_pkg::ST_SFILL;
        else state_nxt = atte_pkg::ST_COPY_RD;
      end
      atte_pkg::ST_COPY_RD: state_nxt = atte_pkg::ST_COPY_WR;
      atte_pkg::ST_COPY_WR:
        state_nxt = sts.copy_last ? atte_pkg::ST_SFILL : atte_pkg::ST_COPY_RD;
      atte_pkg::ST_SFILL:   if (sts.fill_last) state_nxt = atte_pkg::ST_OUT;
      atte_pkg::ST_OUT:     if (!out_valid_r || out_ready) state_nxt = atte_pkg::ST_IDLE;
      default:              state_nxt = atte_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      atte_pkg::ST_CLEAR:   cmd.fill_step = 1'b1;
      atte_pkg::ST_IDLE:    cmd.load = in_valid;
      atte_pkg::ST_EXEC: begin
        cmd.rd   = sts.kind;
        cmd.exec = !sts.kind;
      end
      atte_pkg::ST_FILL:    cmd.fill_step = 1'b1;
      atte_pkg::ST_SGR:     cmd.sgr_step = 1'b1;
      atte_pkg::ST_CHECK:   cmd.scroll_start = sts.need_scroll;
      atte_pkg::ST_COPY_RD: cmd.copy_rd = 1'b1;
      atte_pkg::ST_COPY_WR: cmd.copy_wr = 1'b1;
      atte_pkg::ST_SFILL:   cmd.fill_step = 1'b1;
      atte_pkg::ST_OUT:     cmd.out_load = !out_valid_r || out_ready;
      default:              cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atte_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == atte_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/atte_dp.sv -----
// Datapath for the terminal engine: cell store, cursor, colour, parser, sweeps.
// Depends on atte_pkg; driven by atte_ctrl commands.
module atte_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [atte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atte_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_kind,
  input  logic [atte_pkg::CHAR_W-1:0]        in_char_byte,
  input  logic [atte_pkg::RROW_W-1:0]        in_read_row,
  input  logic [atte_pkg::RCOL_W-1:0]        in_read_col,
  input  atte_pkg::cmd_t                     cmd,
  output atte_pkg::sts_t                     sts,
  output logic [atte_pkg::OROW_W-1:0]        out_cursor_row,
  output logic [atte_pkg::COL_W-1:0]         out_cursor_col,
  output logic [atte_pkg::LIN_W-1:0]         out_cursor_linear,
  output logic [atte_pkg::COLOR_W-1:0]       out_text_color,
  output logic [atte_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [atte_pkg::COLOR_W-1:0]       out_cell_color
);

  localparam int CW = atte_pkg::COL_W;
  localparam int RW = atte_pkg::ROW_W;
  localparam int RI = atte_pkg::ROWI_W;
  localparam int CI = atte_pkg::COLI_W;
  localparam int PW = atte_pkg::PARAM_W;
  localparam int CELL_W = atte_pkg::CHAR_W + atte_pkg::COLOR_W;

  function automatic logic [7:0] sgr_apply(input logic [7:0] col, input logic [PW-1:0] p);
    logic [PW-1:0] d30, d40, d90, d100;
    logic [7:0]    res;
    d30  = p - PW'(30);
    d40  = p - PW'(40);
    d90  = p - PW'(90);
    d100 = p - PW'(100);
    res  = col;
    if (p == PW'(0)) res = atte_pkg::DEFAULT_COLOR;
    else if (p == PW'(1)) res = col | atte_pkg::BRIGHT_FG;
    else if (p == PW'(7)) res = {col[3:0], col[7:4]};
    else if (p >= PW'(30) && p <= PW'(37))
      res = {col[7:4], 1'b0, atte_pkg::SGR_MAP[d30[2:0]]};
    else if (p >= PW'(90) && p <= PW'(97))
      res = {col[7:4], 1'b1, atte_pkg::SGR_MAP[d90[2:0]]};
    else if (p >= PW'(40) && p <= PW'(47))
      res = {1'b0, atte_pkg::SGR_MAP[d40[2:0]], col[3:0]};
    else if (p >= PW'(100) && p <= PW'(107))
      res = {1'b1, atte_pkg::SGR_MAP[d100[2:0]], col[3:0]};
    return res;
  endfunction

  // configuration
  logic [CW-1:0]                 columns_r;
  logic [atte_pkg::CROWS_W-1:0]  rows_r;

  // latched item
  logic                          kind_r;
  logic [7:0]                    byte_r;
  logic [atte_pkg::RROW_W-1:0]   rrow_r;
  logic [atte_pkg::RCOL_W-1:0]   rcol_r;

  // terminal state
  logic [RW-1:0]                 crow_r;
  logic [CW-1:0]                 ccol_r;
  logic [7:0]                    color_r;
  atte_pkg::parse_mode_t         mode_r;
  logic [PW-1:0]                 param_r [atte_pkg::MAX_PARAMS];
  logic [atte_pkg::PCNT_W-1:0]   pcnt_r;
  logic [atte_pkg::PIDX_W-1:0]   sidx_r;

  // sweep
  logic [RI-1:0]                 fr_r, fr1_r;
  logic [CW-1:0]                 fc_r, fce_r, fco_r;
  logic [7:0]                    fch_r;

  // cell store
  logic [CELL_W-1:0]             mem [2**atte_pkg::ADDR_W];
  logic [CELL_W-1:0]             rdata_r;
  logic                          mem_we, mem_re;
  logic [atte_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CELL_W-1:0]             mem_wdata;

  // decode
  atte_pkg::act_t                d_act;
  atte_pkg::parse_mode_t         d_mode;
  logic [RW-1:0]                 d_crow;
  logic [CW-1:0]                 d_ccol;
  logic [atte_pkg::PCNT_W-1:0]   d_pcnt;
  logic                          d_pwe;
  logic [atte_pkg::PIDX_W-1:0]   d_pidx;
  logic [PW-1:0]                 d_pval;
  logic [RI-1:0]                 d_fr, d_fr1;
  logic [CW-1:0]                 d_fc, d_fce;
  logic [7:0]                    d_fch;

  logic [PW-1:0]                 pa, pb, nn, hr, hc;
  logic [CW:0]                   ccol1;
  logic [CW-1:0]                 ccol1_cap;
  logic [atte_pkg::CROWS_W-1:0]  rows_m1;
  logic [CW-1:0]                 cols_m1;
  logic [PW:0]                   sum_r, sum_c;
  logic [atte_pkg::PIDX_W-1:0]   pidx_cur;
  logic [PW+3:0]                 dig_full;
  logic [PW-1:0]                 dig_sat;
  logic [atte_pkg::PCNT_W-1:0]   pc1, semi_cnt;
  logic [atte_pkg::PCNT_W-1:0]   semi_m1;
  logic [RW-1:0]                 bs_r;
  logic [CW-1:0]                 bs_c;
  logic [CW:0]                   stop9;
  logic [CW-1:0]                 tab_lim;

  logic [CW-1:0]                 fend;
  logic                          f_at_end;
  logic [CW:0]                   fc1;
  logic [PW-1:0]                 sgr_val;
  logic [atte_pkg::CROWS_W-1:0]  rows_m2;
  logic [RW+CW:0]                lin_full;
  logic [CW-1:0]                 cfg_cols;
  logic [atte_pkg::CROWS_W-1:0]  cfg_rows;

  assign pa        = (pcnt_r > 0) ? param_r[0] : '0;
  assign pb        = (pcnt_r > 1) ? param_r[1] : '0;
  assign nn        = (pa == '0) ? PW'(1) : pa;
  assign hr        = (pa > 0) ? pa - PW'(1) : '0;
  assign hc        = (pb > 0) ? pb - PW'(1) : '0;
  assign ccol1     = {1'b0, ccol_r} + (CW+1)'(1);
  assign ccol1_cap = (ccol1 > (CW+1)'(atte_pkg::MAX_COLS)) ? CW'(atte_pkg::MAX_COLS)
                                                          : ccol1[CW-1:0];
  assign rows_m1   = rows_r - 1'b1;
  assign rows_m2   = rows_r - 7'd2;
  assign cols_m1   = columns_r - 1'b1;
  assign sum_r     = (PW+1)'(crow_r) + (PW+1)'(nn);
  assign sum_c     = (PW+1)'(ccol_r) + (PW+1)'(nn);
  assign pidx_cur  = (pcnt_r == '0) ? '0 : atte_pkg::PIDX_W'(pcnt_r - 1'b1);
  assign dig_full  = ((PW+4)'(param_r[pidx_cur]) << 3) + ((PW+4)'(param_r[pidx_cur]) << 1)
                     + (PW+4)'(byte_r - atte_pkg::BYTE_ZERO);
  assign dig_sat   = (dig_full > (PW+4)'(16'hFFFF)) ? 16'hFFFF : dig_full[PW-1:0];
  assign pc1       = (pcnt_r == '0) ? atte_pkg::PCNT_W'(1) : pcnt_r;
  assign semi_cnt  = (pc1 < atte_pkg::PCNT_W'(atte_pkg::MAX_PARAMS)) ? pc1 + 1'b1 : pc1;
  assign semi_m1   = semi_cnt - 1'b1;
  assign bs_r      = (ccol_r == '0 && crow_r != '0) ? crow_r - 1'b1 : crow_r;
  assign bs_c      = (ccol_r != '0) ? ccol_r - 1'b1 : ((crow_r != '0) ? cols_m1 : ccol_r);
  assign stop9     = ({1'b0, ccol_r} + (CW+1)'(8)) & ~(CW+1)'(7);
  assign tab_lim   = (stop9 > {1'b0, columns_r}) ? columns_r : stop9[CW-1:0];

  always_comb begin
    d_act  = atte_pkg::ACT_PLAIN;
    d_mode = mode_r;
    d_crow = crow_r;
    d_ccol = ccol_r;
    d_pcnt = pcnt_r;
    d_pwe  = 1'b0;
    d_pidx = '0;
    d_pval = '0;
    d_fr   = crow_r[RI-1:0];
    d_fc   = ccol_r;
    d_fr1  = crow_r[RI-1:0];
    d_fce  = ccol1_cap;
    d_fch  = atte_pkg::BLANK_CHAR;
    unique case (mode_r)
      atte_pkg::PM_ESC: begin
        d_act = atte_pkg::ACT_DONE;
        if (byte_r == atte_pkg::BYTE_CSI) begin
          d_mode = atte_pkg::PM_CSI;
          d_pcnt = '0;
          d_pwe  = 1'b1;
        end else begin
          d_mode = atte_pkg::PM_NORMAL;
        end
      end
      atte_pkg::PM_CSI: begin
        priority if (byte_r == atte_pkg::BYTE_PRIV) begin
          d_act = atte_pkg::ACT_PLAIN;
        end else if (byte_r >= atte_pkg::BYTE_ZERO && byte_r <= atte_pkg::BYTE_NINE) begin
          d_pcnt = pc1;
          d_pwe  = 1'b1;
          d_pidx = pidx_cur;
          d_pval = dig_sat;
        end else if (byte_r == atte_pkg::BYTE_SEMI) begin
          d_pcnt = semi_cnt;
          d_pwe  = 1'b1;
          d_pidx = semi_m1[atte_pkg::PIDX_W-1:0];
        end else begin
          d_mode = atte_pkg::PM_NORMAL;
          unique case (byte_r)
            atte_pkg::FIN_CUU:
              d_crow = ((PW)'(crow_r) >= nn) ? crow_r - nn[RW-1:0] : '0;
            atte_pkg::FIN_CUD:
              d_crow = (sum_r >= (PW+1)'(rows_r)) ? rows_m1 : sum_r[RW-1:0];
            atte_pkg::FIN_CUF:
              d_ccol = (sum_c >= (PW+1)'(columns_r)) ? cols_m1 : sum_c[CW-1:0];
            atte_pkg::FIN_CUB:
              d_ccol = ((PW)'(ccol_r) >= nn) ? ccol_r - nn[CW-1:0] : '0;
            atte_pkg::FIN_CUP, atte_pkg::FIN_HVP: begin
              d_crow = (hr >= PW'(rows_r)) ? rows_m1 : hr[RW-1:0];
              d_ccol = (hc >= PW'(columns_r)) ? cols_m1 : hc[CW-1:0];
            end
            atte_pkg::FIN_ED: begin
              if (pa == PW'(2) || pa == PW'(3)) begin
                d_act  = atte_pkg::ACT_FILL;
                d_fr   = '0;
                d_fc   = '0;
                d_fr1  = rows_m1[RI-1:0];
                d_fce  = columns_r;
                d_crow = '0;
                d_ccol = '0;
              end else if (pa == PW'(0)) begin
                d_act = atte_pkg::ACT_FILL;
                d_fr1 = (crow_r >= rows_r) ? crow_r[RI-1:0] : rows_m1[RI-1:0];
                d_fce = columns_r;
              end else if (pa == PW'(1)) begin
                d_act = atte_pkg::ACT_FILL;
                d_fr  = '0;
                d_fc  = '0;
              end
            end
            atte_pkg::FIN_EL: begin
              if (pa == PW'(0)) begin
                d_act = atte_pkg::ACT_FILL;
                d_fce = columns_r;
              end else if (pa == PW'(1)) begin
                d_act = atte_pkg::ACT_FILL;
                d_fc  = '0;
              end else if (pa == PW'(2)) begin
                d_act = atte_pkg::ACT_FILL;
                d_fc  = '0;
                d_fce = columns_r;
              end
            end
            atte_pkg::FIN_SGR: d_act = atte_pkg::ACT_SGR;
            default: d_act = atte_pkg::ACT_PLAIN;
          endcase
        end
      end
      atte_pkg::PM_NORMAL: begin
        priority if (byte_r == atte_pkg::BYTE_ESC) begin
          d_act  = atte_pkg::ACT_DONE;
          d_mode = atte_pkg::PM_ESC;
        end else if (byte_r == atte_pkg::BYTE_LF) begin
          d_ccol = '0;
          d_crow = crow_r + 1'b1;
        end else if (byte_r == atte_pkg::BYTE_CR) begin
          d_ccol = '0;
        end else if (byte_r == atte_pkg::BYTE_BS) begin
          d_act  = atte_pkg::ACT_FILL;
          d_crow = bs_r;
          d_ccol = bs_c;
          d_fr   = bs_r[RI-1:0];
          d_fr1  = bs_r[RI-1:0];
          d_fc   = bs_c;
          d_fce  = bs_c + 1'b1;
        end else if (byte_r == atte_pkg::BYTE_TAB) begin
          if (ccol_r < tab_lim) begin
            d_act  = atte_pkg::ACT_FILL;
            d_fce  = tab_lim;
            d_ccol = tab_lim;
          end
        end else begin
          d_act = atte_pkg::ACT_FILL;
          d_fch = byte_r;
          if (ccol1 >= {1'b0, columns_r}) begin
            d_ccol = '0;
            d_crow = crow_r + 1'b1;
          end else begin
            d_ccol = ccol1[CW-1:0];
          end
        end
      end
      default: begin
        d_act  = atte_pkg::ACT_DONE;
        d_mode = atte_pkg::PM_NORMAL;
      end
    endcase
  end

  assign fend     = (fr_r == fr1_r) ? fce_r : fco_r;
  assign fc1      = {1'b0, fc_r} + 1'b1;
  assign f_at_end = (fc1 >= {1'b0, fend});
  assign sgr_val  = (pcnt_r == '0) ? '0 : param_r[sidx_r];
  assign lin_full = (RW+CW+1)'(crow_r * columns_r) + (RW+CW+1)'(ccol_r);
  assign cfg_cols = (cfg_data == '0) ? CW'(1)
                  : ((cfg_data > CW'(atte_pkg::MAX_COLS)) ? CW'(atte_pkg::MAX_COLS) : cfg_data);
  assign cfg_rows = (cfg_data[6:0] == '0) ? 7'd1
                  : ((cfg_data[6:0] > 7'(atte_pkg::MAX_ROWS)) ? 7'(atte_pkg::MAX_ROWS)
                                                             : cfg_data[6:0]);

  assign sts.kind        = kind_r;
  assign sts.act         = d_act;
  assign sts.fill_last   = (fr_r == fr1_r) && f_at_end;
  assign sts.sgr_last    = (pcnt_r == '0) || (({1'b0, sidx_r} + 1'b1) >= pcnt_r);
  assign sts.need_scroll = (crow_r >= rows_r);
  assign sts.copy_none   = (rows_r < 7'd2);
  assign sts.copy_last   = ({1'b0, fr_r} == rows_m2) && (fc1 >= {1'b0, columns_r});

  assign mem_we    = (cmd.fill_step && (fc_r < fend)) || cmd.copy_wr;
  assign mem_waddr = {fr_r, fc_r[CI-1:0]};
  assign mem_wdata = cmd.copy_wr ? rdata_r : {fch_r, color_r};
  assign mem_re    = cmd.rd || cmd.copy_rd;
  assign mem_raddr = cmd.rd ? {rrow_r, rcol_r} : {fr_r + 1'b1, fc_r[CI-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= atte_pkg::COLUMNS_RST;
      rows_r    <= atte_pkg::ROWS_RST;
      crow_r    <= '0;
      ccol_r    <= '0;
      color_r   <= atte_pkg::DEFAULT_COLOR;
      mode_r    <= atte_pkg::PM_NORMAL;
      pcnt_r    <= '0;
      sidx_r    <= '0;
      for (int i = 0; i < atte_pkg::MAX_PARAMS; i++) param_r[i] <= '0;
      fr_r      <= '0;
      fc_r      <= '0;
      fr1_r     <= RI'(atte_pkg::MAX_ROWS - 1);
      fce_r     <= CW'(atte_pkg::MAX_COLS);
      fco_r     <= CW'(atte_pkg::MAX_COLS);
      fch_r     <= atte_pkg::BLANK_CHAR;
    end else begin
      if (cfg_we && cfg_index == atte_pkg::CFG_COLUMNS) columns_r <= cfg_cols;
      if (cfg_we && cfg_index == atte_pkg::CFG_ROWS) rows_r <= cfg_rows;
      if (cmd.exec) begin
        mode_r <= d_mode;
        crow_r <= d_crow;
        ccol_r <= d_ccol;
        pcnt_r <= d_pcnt;
        sidx_r <= '0;
        if (d_pwe) param_r[d_pidx] <= d_pval;
        if (d_act == atte_pkg::ACT_FILL) begin
          fr_r  <= d_fr;
          fc_r  <= d_fc;
          fr1_r <= d_fr1;
          fce_r <= d_fce;
          fco_r <= columns_r;
          fch_r <= d_fch;
        end
      end
      if (cmd.sgr_step) begin
        color_r <= sgr_apply(color_r, sgr_val);
        sidx_r  <= sidx_r + 1'b1;
      end
      if (cmd.fill_step && !sts.fill_last) begin
        if (!f_at_end) begin
          fc_r <= fc1[CW-1:0];
        end else begin
          fr_r <= fr_r + 1'b1;
          fc_r <= '0;
        end
      end
      if (cmd.scroll_start) begin
        crow_r <= RW'(rows_m1);
        fr_r   <= sts.copy_none ? rows_m1[RI-1:0] : '0;
        fc_r   <= '0;
        fr1_r  <= rows_m1[RI-1:0];
        fce_r  <= columns_r;
        fco_r  <= columns_r;
        fch_r  <= atte_pkg::BLANK_CHAR;
      end
      if (cmd.copy_wr) begin
        if (sts.copy_last) begin
          fr_r <= rows_m1[RI-1:0];
          fc_r <= '0;
        end else if (fc1 >= {1'b0, columns_r}) begin
          fr_r <= fr_r + 1'b1;
          fc_r <= '0;
        end else begin
          fc_r <= fc1[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      byte_r <= in_char_byte;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.out_load) begin
      out_cursor_row    <= crow_r[atte_pkg::OROW_W-1:0];
      out_cursor_col    <= ccol_r;
      out_cursor_linear <= lin_full[atte_pkg::LIN_W-1:0];
      out_text_color    <= color_r;
      out_cell_char     <= kind_r ? rdata_r[CELL_W-1:atte_pkg::COLOR_W] : '0;
      out_cell_color    <= kind_r ? rdata_r[atte_pkg::COLOR_W-1:0] : '0;
    end
  end

endmodule

// ----- hdl/ansi_text_terminal_engine_top.sv -----
// A cell read goes ST_EXEC, ST_OUT; a plain byte or CSI digit adds ST_CHECK; a
// printable byte or erase adds ST_FILL over its cells; SGR adds ST_SGR per
// parameter. Scroll copies (rows-1)*columns cells (read, then write) and blanks
// columns cells. One item at a time; cell store has one write and one read port
// per cycle. After rst_n (synchronous, active low) a clearing pass over all 8192
// cells fills the store with spaces in colour 0x0F; in_tready stays low until done.
module ansi_text_terminal_engine_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [atte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [atte_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // char_byte[7:0], read_row[13:8], read_col[20:14], zero [23:21]
  input  logic [atte_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cursor_row_out[5:0], cursor_col_out[13:6], cursor_linear[27:14],
  // text_color[35:28], cell_char[43:36], cell_color[51:44], zero [55:52]
  output logic [atte_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  atte_pkg::cmd_t cmd;
  atte_pkg::sts_t sts;

  logic [atte_pkg::OROW_W-1:0]   o_row;
  logic [atte_pkg::COL_W-1:0]    o_col;
  logic [atte_pkg::LIN_W-1:0]    o_lin;
  logic [atte_pkg::COLOR_W-1:0]  o_color;
  logic [atte_pkg::CHAR_W-1:0]   o_cchar;
  logic [atte_pkg::COLOR_W-1:0]  o_ccolor;

  atte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  atte_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_tuser),
    .in_char_byte      (in_tdata[7:0]),
    .in_read_row       (in_tdata[13:8]),
    .in_read_col       (in_tdata[20:14]),
    .cmd               (cmd),
    .sts               (sts),
    .out_cursor_row    (o_row),
    .out_cursor_col    (o_col),
    .out_cursor_linear (o_lin),
    .out_text_color    (o_color),
    .out_cell_char     (o_cchar),
    .out_cell_color    (o_ccolor)
  );

  assign out_tdata = {4'b0, o_ccolor, o_cchar, o_color, o_lin, o_col, o_row};

endmodule

// ----- hdl/atte_checker.sv -----
// Port-level checks for the terminal engine, bound to the top level.
// Depends on atte_pkg and ansi_text_terminal_engine_top_macros.svh.
`include "ansi_text_terminal_engine_top_macros.svh"

module atte_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [atte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [atte_pkg::CFG_DATA_W-1:0]     cfg_data,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [atte_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [atte_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  `ATTE_ASSERT_RST(a_rst_no_out, !rst_n, !out_tvalid, "result valid right after reset")
  `ATTE_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `ATTE_ASSERT_NOW(a_drop_taken, $fell(out_tvalid), $past(out_tready), "result dropped untaken")
  `ATTE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind ansi_text_terminal_engine_top atte_checker u_atte_checker (.*);
